/* rtl/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions for the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int QueueDepth = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} item_t;

	localparam logic [31:0] RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos  = 6'd56;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

/* rtl/sha256_queue.sv */
// ----------------------------------------------------------------------------
// SHA-256 item queue
// Small FIFO between the input front end and the hashing engine.
// ----------------------------------------------------------------------------
module sha256_queue
	import sha256_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);
	localparam int AW = $clog2(QueueDepth);

	item_t           mem_q [QueueDepth];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;
	logic            push, pop;

	assign in_ready  = (cnt_q != (AW+1)'(QueueDepth));
	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

/* rtl/sha256_front.sv */
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts input transfers, drops items that carry neither byte nor end.
// ----------------------------------------------------------------------------
module sha256_front
	import sha256_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       ready,
	input  logic [7:0] data_byte,
	input  logic       has_byte,
	input  logic       end_of_message,
	output logic       q_valid,
	input  logic       q_ready,
	output item_t      q_item
);
	logic  hold_q;
	item_t item_q;

	// one-entry input register; empty items are accepted and discarded
	assign ready   = !hold_q || q_ready;
	assign q_valid = hold_q;
	assign q_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (ready) begin
			hold_q <= valid && (has_byte || end_of_message);
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) item_q <= '{data_byte, has_byte, end_of_message};
	end
endmodule

/* rtl/sha256_engine.sv */
// ----------------------------------------------------------------------------
// SHA-256 engine
// Block buffer, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
module sha256_engine
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  item_t       q_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_RUN, ST_FOLD, ST_OUT
	} state_t;

	state_t       state_q;
	logic [31:0]  w_q [16];     // block words, then rolling schedule
	logic [31:0]  h_q [8];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0]   fill_q;
	logic [5:0]   rnd_q;
	logic [60:0]  len_q;
	logic         final_q;      // block being run is the last one
	logic         more_q;       // a further padding block follows
	logic         pad_done_q;   // 0x80 already placed in an earlier block
	logic [2:0]   oidx_q;

	logic [31:0] wt, t1, t2, wnew;
	logic [63:0] bitlen;

	assign bitlen = {len_q, 3'b000};
	assign wt   = w_q[0];
	assign wnew = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
	assign t1   = hh_q + bsig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) + RoundConst[rnd_q] + wt;
	assign t2   = bsig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	assign q_ready     = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = h_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

	// write one byte into the word buffer
	function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
		input logic [7:0] b);
		logic [31:0] r;
		r = w;
		r[31 - 8*pos -: 8] = b;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			len_q      <= '0;
			rnd_q      <= '0;
			final_q    <= 1'b0;
			more_q     <= 1'b0;
			pad_done_q <= 1'b0;
			oidx_q     <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_item.has_byte) begin
							w_q[fill_q[5:2]] <= put_byte(w_q[fill_q[5:2]], fill_q[1:0],
								q_item.data_byte);
							fill_q <= fill_q + 6'd1;
							len_q  <= len_q + 61'd1;
						end
						final_q <= 1'b0;
						more_q  <= q_item.end_of_message;
						if (q_item.has_byte && fill_q == 6'd63) state_q <= ST_RUN;
						else if (q_item.end_of_message) state_q <= ST_PAD;
						rnd_q <= '0;
						a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
						e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
					end
				end
				ST_PAD: begin
					// place 0x80 unless an earlier block took it, zero the rest,
					// add length if it fits
					for (int i = 0; i < 16; i++) begin
						logic [31:0] m, v;
						v = w_q[i];
						if (pad_done_q || 6'(4*i) > fill_q) v = '0;
						else if (6'(4*i) + 6'd3 >= fill_q) begin
							m = 32'hffffffff << (8 * (4 - (int'(fill_q) - 4*i)));
							if (fill_q[1:0] == 2'd0) m = '0;
							v = (v & m) | (32'(PadByte) << (8 * (3 - int'(fill_q[1:0]))));
						end
						if (fill_q < LenPos && i == 14) v = bitlen[63:32];
						if (fill_q < LenPos && i == 15) v = bitlen[31:0];
						w_q[i] <= v;
					end
					if (fill_q < LenPos) begin
						final_q    <= 1'b1;
						more_q     <= 1'b0;
						pad_done_q <= 1'b0;
					end else begin
						final_q    <= 1'b0;
						more_q     <= 1'b1;
						pad_done_q <= 1'b1;
					end
					fill_q <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
					d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wnew;
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
					h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
					rnd_q <= '0;
					if (final_q) begin
						oidx_q  <= '0;
						state_q <= ST_OUT;
					end else if (more_q) begin
						// pending end: block is empty here, pad it or send length only
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= ST_IDLE;
							len_q   <= '0;
							fill_q  <= '0;
							for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// a following pad block: load its start state on the way into ST_PAD after fold
			if (state_q == ST_FOLD && !final_q && more_q) begin
				a_q <= h_q[0] + a_q; b_q <= h_q[1] + b_q; c_q <= h_q[2] + c_q;
				d_q <= h_q[3] + d_q; e_q <= h_q[4] + e_q; f_q <= h_q[5] + f_q;
				g_q <= h_q[6] + g_q; hh_q <= h_q[7] + hh_q;
			end
		end
	end
endmodule

/* rtl/sha256_message_digest_top.sv */
// ----------------------------------------------------------------------------
// SHA-256 message digest top
// Byte-serial SHA-256 hasher with padding and word-serial digest output.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | valid / ready        | data_byte, has_byte, end_of_message
//  output   | out_valid/out_ready  | digest_word, word_index, last_word
//
// The engine takes in bytes while idle; a full block then runs its rounds and
// a fold in the single shared round unit. End of message adds, for each of
// its one or two final blocks, a pad step plus the rounds and a fold, then
// eight output transfers.
// Reset (arst_n low) loads the initial hash and clears counts; the block
// buffer holds no reset value. A four-entry queue lets the front end keep
// taking transfers while the engine runs rounds or waits on out_ready.
module sha256_message_digest_top
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	logic  f_valid, f_ready, e_valid, e_ready;
	item_t f_item, e_item;

	sha256_front u_front (
		.clk, .arst_n, .valid, .ready, .data_byte, .has_byte, .end_of_message,
		.q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
	);

	sha256_queue u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
		.out_valid(e_valid), .out_ready(e_ready), .out_item(e_item)
	);

	sha256_engine u_engine (
		.clk, .arst_n,
		.q_valid(e_valid), .q_ready(e_ready), .q_item(e_item),
		.out_valid, .out_ready, .digest_word, .word_index, .last_word
	);
endmodule

/* tb/sha256_message_digest_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 message digest testbench
// Feeds messages a byte at a time under random valid/ready pressure, hashes
// them alongside in plain SystemVerilog and checks every digest word.
// ----------------------------------------------------------------------------
module sha256_message_digest_top_tb;
	import sha256_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_t;

	// Digest word store plus running hash state of the message in flight.
	class digest_board;
		digest_t     pending[$];
		logic [31:0] chain[8];
		logic [7:0]  blk[64];
		int unsigned fill;
		logic [60:0] nbytes;
		int          mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++) chain[i] = InitHash[i];
			fill = 0;
			nbytes = '0;
		endfunction

		function logic [31:0] ror(logic [31:0] v, int n);
			return (v >> n) | (v << (32 - n));
		endfunction

		function void crunch();
			logic [31:0] w[64];
			logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
			for (int t = 0; t < 16; t++)
				w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			for (int t = 16; t < 64; t++)
				w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
					+ w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
			{a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
				chain[4], chain[5], chain[6], chain[7]};
			for (int t = 0; t < 64; t++) begin
				t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
					+ RoundConst[t] + w[t];
				t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
				h = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + t2;
			end
			chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
			chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
		endfunction

		function void note_transfer(logic [7:0] db, logic hb, logic eom);
			logic [63:0] bits;
			digest_t dw;
			if (hb) begin
				blk[fill] = db;
				fill++;
				nbytes++;
				if (fill == 64) begin
					crunch();
					fill = 0;
				end
			end
			if (!eom) return;
			bits = {nbytes, 3'b000};
			blk[fill] = PadByte;
			fill++;
			if (fill > LenPos) begin
				while (fill < 64) blk[fill++] = 8'h00;
				crunch();
				fill = 0;
			end
			while (fill < LenPos) blk[fill++] = 8'h00;
			for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
			crunch();
			for (int i = 0; i < 8; i++) begin
				dw.word = chain[i];
				dw.idx  = i[2:0];
				dw.last = (i == 7);
				pending = {pending, dw};
			end
			restart();
		endfunction

		function void check_word(digest_t got);
			digest_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digest word %h idx %0d last %0b",
						got.word, got.idx, got.last);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
						exp.word, exp.idx, exp.last, got.word, got.idx, got.last);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        valid = 0;
	logic        ready;
	logic [7:0]  data_byte = '0;
	logic        has_byte = 0;
	logic        end_of_message = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_board board = new();
	int send_idle = 0;  // percent of cycles the sender holds off
	int sink_stall = 0; // percent of cycles the receiver stalls

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	sha256_message_digest_top dut (.*);

	// Receiver: random ready at the falling edge, check on accepted transfers.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_word({digest_word, word_index, last_word});
	end

	always @(negedge clk)
		out_ready <= arst_n && ($urandom_range(99) >= sink_stall);

	// One transfer; idle gaps drop valid before the next item goes out.
	// Valid stays high after the accept until the next send or drain.
	task automatic send(logic [7:0] db, logic hb, logic eom);
		while ($urandom_range(99) < send_idle) begin
			valid <= 0;
			@(negedge clk);
		end
		valid <= 1;
		data_byte <= db;
		has_byte <= hb;
		end_of_message <= eom;
		do @(posedge clk); while (!ready);
		board.note_transfer(db, hb, eom);
		@(negedge clk);
	endtask

	task automatic send_message(int len, int mode);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			// mode 1: all 0x00, 2: all 0xff, else random
			b = (mode == 1) ? 8'h00 : (mode == 2) ? 8'hff : 8'($urandom);
			// stray no-op items now and then
			if ($urandom_range(15) == 0) send(8'($urandom), 0, 0);
			send(b, 1, (i == len - 1) && ($urandom_range(1) == 1));
		end
		// close with a bare end unless the last byte already carried it
		if (len == 0 || !end_of_message) send(8'($urandom), 0, 1);
	endtask

	task automatic drain();
		valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	initial begin
		int len;
		repeat (3) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: empty message, one byte, boundaries around 55/56/64 bytes.
		send(8'hff, 0, 1);
		send(8'h61, 1, 1);
		send(8'h00, 0, 0);
		send(8'h00, 0, 1);
		send_message(55, 1);
		send_message(56, 2);
		send_message(64, 0);
		drain();  // sender pause with all digests in

		for (int phase = 0; phase < 4; phase++) begin
			send_idle  = (phase == 1 || phase == 3) ? ((phase == 3) ? 10 : 61) : 0;
			sink_stall = (phase == 2 || phase == 3) ? ((phase == 3) ? 10 : 61) : 0;
			for (int m = 0; m < 4; m++) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(70) : $urandom_range(4);
				send_message(len, 0);
			end
		end
		drain();
		if (board.mismatches == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/sha256_pkg.sv
rtl/sha256_queue.sv
rtl/sha256_front.sv
rtl/sha256_engine.sv
rtl/sha256_message_digest_top.sv
tb/sha256_message_digest_top_tb.sv
